[hw/rtl/hsv_color_region_fill_unit_defines.svh]
// assertion macros used by hsv_color_region_fill_unit
`ifndef HSV_COLOR_REGION_FILL_UNIT_DEFINES_SVH
`define HSV_COLOR_REGION_FILL_UNIT_DEFINES_SVH

// same-cycle implication, checked after reset
`define HSVCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked after reset
`define HSVCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hsvcr_pkg.sv]
package hsvcr_pkg;

    // field widths
    localparam int COMMAND_W      = 1;
    localparam int REGION_INDEX_W = 3;
    localparam int HUE_W          = 9;
    localparam int CHAN_W         = 8;
    localparam int COLOR_WORD_W   = 32;
    localparam int FILL_W         = 24;
    localparam int REGION_HIT_W   = 3;
    localparam int FILL_MODE_W    = 3;
    localparam int REGION_COUNT_W = 4;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    // hue arithmetic runs signed, wide enough for the wrap terms
    localparam int HUE_DIFF_W = HUE_W + 2;
    localparam logic signed [HUE_DIFF_W-1:0] HUE_CIRCLE = 11'sd360;

    localparam logic [CHAN_W-1:0] MID_GRAY  = 8'd127;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_LOAD     = 1'b0,
        CMD_CLASSIFY = 1'b1
    } t_command;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILL_MODE    = 1'b0,
        CFG_REGION_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [FILL_MODE_W-1:0] {
        FILL_IDENTITY   = 3'd0,
        FILL_ORIGINAL   = 3'd1,
        FILL_BLACK      = 3'd2,
        FILL_WHITE      = 3'd3,
        FILL_MID_GRAY   = 3'd4,
        FILL_VALUE_GRAY = 3'd5
    } t_fill_mode;

    // one region's acceptance window
    typedef struct packed {
        logic [HUE_W-1:0]  hue_ref;
        logic [HUE_W-1:0]  hue_tolerance;
        logic [CHAN_W-1:0] sat_min;
        logic [CHAN_W-1:0] sat_max;
        logic [CHAN_W-1:0] val_min;
        logic [CHAN_W-1:0] val_max;
    } t_bounds;

    // one input transaction as held in the first stage
    typedef struct packed {
        t_command                  command;
        logic [REGION_INDEX_W-1:0] region_index;
        t_bounds                   bounds;
        logic [HUE_W-1:0]          pixel_hue;
        logic [CHAN_W-1:0]         pixel_sat;
        logic [CHAN_W-1:0]         pixel_val;
        logic [COLOR_WORD_W-1:0]   color_word;
    } t_item;

endpackage

[hw/rtl/hsvcr_in_if.sv]
interface hsvcr_in_if
    import hsvcr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [COMMAND_W-1:0]      command;
    logic [REGION_INDEX_W-1:0] region_index;
    logic [HUE_W-1:0]          hue_ref;
    logic [HUE_W-1:0]          hue_tolerance;
    logic [CHAN_W-1:0]         sat_min;
    logic [CHAN_W-1:0]         sat_max;
    logic [CHAN_W-1:0]         val_min;
    logic [CHAN_W-1:0]         val_max;
    logic [HUE_W-1:0]          pixel_hue;
    logic [CHAN_W-1:0]         pixel_sat;
    logic [CHAN_W-1:0]         pixel_val;
    logic [COLOR_WORD_W-1:0]   color_word;

    modport source (
        output valid, command, region_index, hue_ref, hue_tolerance, sat_min, sat_max,
               val_min, val_max, pixel_hue, pixel_sat, pixel_val, color_word,
        input  ready
    );

    modport sink (
        input  valid, command, region_index, hue_ref, hue_tolerance, sat_min, sat_max,
               val_min, val_max, pixel_hue, pixel_sat, pixel_val, color_word,
        output ready
    );
endinterface

[hw/rtl/hsvcr_out_if.sv]
interface hsvcr_out_if
    import hsvcr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CHAN_W-1:0]       red;
    logic [CHAN_W-1:0]       green;
    logic [CHAN_W-1:0]       blue;
    logic [CHAN_W-1:0]       alpha;
    logic                    matched;
    logic [REGION_HIT_W-1:0] region_hit;

    modport source (
        output valid, red, green, blue, alpha, matched, region_hit,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, alpha, matched, region_hit,
        output ready
    );
endinterface

[hw/rtl/hsv_color_region_fill_unit.sv]
// channel   dir  payload                                           role
// i_pix     in   command, region_index, bounds, pixel hsv, color   load entry / classify pixel
// o_res     out  red, green, blue, alpha, matched, region_hit      one per classify, none if fill_mode > 5
// i_cfg_*   in   wr_en, index, data                                fill_mode, region_count
//
// one transaction per cycle while o_res is not stalled; a taken pixel is registered in stage 1,
// then stage 2, then the output register: stage 1 holds the transaction, the region compares
// feed stage 2, the priority pick and fill select feed the output register; all regions compare in parallel
// loads write the window table leaving stage 1 and the fill table leaving stage 2
// reset clears the pipeline and config registers; the region tables stay undefined
// a stall on o_res backs up through the stages to i_pix.ready; a load in stage 2 never waits
`include "hsv_color_region_fill_unit_defines.svh"

module hsv_color_region_fill_unit
    import hsvcr_pkg::*;
#(
    parameter int REGIONS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    hsvcr_in_if.sink               i_pix,
    hsvcr_out_if.source            o_res
);

    localparam int HIT_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    // hue within tolerance, measured around the circle
    function automatic logic hue_near(
        input logic [HUE_W-1:0] hue,
        input logic [HUE_W-1:0] center,
        input logic [HUE_W-1:0] tol
    );
        logic signed [HUE_DIFF_W-1:0] d;
        logic signed [HUE_DIFF_W-1:0] t;
        logic signed [HUE_DIFF_W-1:0] wrap_dn;
        logic signed [HUE_DIFF_W-1:0] wrap_up;
        logic                         ok;
        d       = signed'({2'b00, hue}) - signed'({2'b00, center});
        t       = signed'({2'b00, tol});
        wrap_dn = HUE_CIRCLE - d;
        wrap_up = HUE_CIRCLE + d;
        if (d > t) begin
            ok = (wrap_dn <= t);
        end else if (d < -t) begin
            ok = (wrap_up <= t);
        end else begin
            ok = 1'b1;
        end
        return ok;
    endfunction

    // configuration registers
    t_fill_mode                r_fill_mode;
    logic [REGION_COUNT_W-1:0] r_region_count;

    // region tables
    t_bounds           r_bounds [REGIONS];
    logic [FILL_W-1:0] r_fill   [REGIONS];

    // pipeline registers
    logic                      r_s1_valid;
    t_item                     r_s1_item;
    logic                      r_s2_valid;
    t_command                  r_s2_cmd;
    logic [REGION_INDEX_W-1:0] r_s2_index;
    logic [COLOR_WORD_W-1:0]   r_s2_color;
    logic [CHAN_W-1:0]         r_s2_val;
    logic [REGIONS-1:0]        r_s2_match;
    logic                      r_s3_valid;
    logic [CHAN_W-1:0]         r_s3_red;
    logic [CHAN_W-1:0]         r_s3_green;
    logic [CHAN_W-1:0]         r_s3_blue;
    logic [CHAN_W-1:0]         r_s3_alpha;
    logic                      r_s3_matched;
    logic [REGION_HIT_W-1:0]   r_s3_hit;

    logic                      n_s1_valid;
    t_item                     n_s1_item;
    logic                      n_s2_valid;
    logic                      n_s3_valid;
    logic [REGIONS-1:0]        n_s2_match;
    logic [CHAN_W-1:0]         n_s3_red;
    logic [CHAN_W-1:0]         n_s3_green;
    logic [CHAN_W-1:0]         n_s3_blue;
    logic [CHAN_W-1:0]         n_s3_alpha;

    // handshake and flow control
    logic                      s3_free;
    logic                      s2_adv;
    logic                      s2_free;
    logic                      s1_keep;
    logic                      s1_adv;
    logic                      s1_free;
    logic                      in_acc;

    // stage 2 selection
    logic [REGIONS-1:0]        s2_onehot;
    logic [HIT_W-1:0]          s2_hit;
    logic [FILL_W-1:0]         s2_fill;
    logic                      s2_found;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_mode    <= FILL_IDENTITY;
            r_region_count <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_FILL_MODE:    r_fill_mode    <= t_fill_mode'(i_cfg_data[FILL_MODE_W-1:0]);
                CFG_REGION_COUNT: r_region_count <= i_cfg_data[REGION_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control: loads leave stage 2 without touching the output
    assign s3_free = !r_s3_valid || o_res.ready;
    assign s2_adv  = r_s2_valid && ((r_s2_cmd == CMD_LOAD) || s3_free);
    assign s2_free = !r_s2_valid || s2_adv;
    assign s1_keep = (r_s1_item.command == CMD_LOAD) || (r_fill_mode <= FILL_VALUE_GRAY);
    assign s1_adv  = r_s1_valid && (!s1_keep || s2_free);
    assign s1_free = !r_s1_valid || s1_adv;
    assign in_acc  = i_pix.valid && s1_free;
    assign i_pix.ready = s1_free;

    assign n_s1_valid = in_acc || (r_s1_valid && !s1_adv);
    assign n_s2_valid = (s1_adv && s1_keep) || (r_s2_valid && !s2_adv);
    assign n_s3_valid = (s2_adv && (r_s2_cmd == CMD_CLASSIFY)) || (r_s3_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
            r_s3_valid <= n_s3_valid;
        end
    end

    // pack the incoming transaction
    always_comb begin
        n_s1_item.command              = t_command'(i_pix.command);
        n_s1_item.region_index         = i_pix.region_index;
        n_s1_item.bounds.hue_ref       = i_pix.hue_ref;
        n_s1_item.bounds.hue_tolerance = i_pix.hue_tolerance;
        n_s1_item.bounds.sat_min       = i_pix.sat_min;
        n_s1_item.bounds.sat_max       = i_pix.sat_max;
        n_s1_item.bounds.val_min       = i_pix.val_min;
        n_s1_item.bounds.val_max       = i_pix.val_max;
        n_s1_item.pixel_hue            = i_pix.pixel_hue;
        n_s1_item.pixel_sat            = i_pix.pixel_sat;
        n_s1_item.pixel_val            = i_pix.pixel_val;
        n_s1_item.color_word           = i_pix.color_word;
    end

    // stage 1: compare against every region in use, skipping region 0 in white fill mode
    always_comb begin
        for (int k = 0; k < REGIONS; k++) begin
            n_s2_match[k] = ((k != 0) || (r_fill_mode != FILL_WHITE))
                && (k < int'(r_region_count))
                && hue_near(r_s1_item.pixel_hue, r_bounds[k].hue_ref,
                            r_bounds[k].hue_tolerance)
                && (r_s1_item.pixel_sat >= r_bounds[k].sat_min)
                && (r_s1_item.pixel_sat <= r_bounds[k].sat_max)
                && (r_s1_item.pixel_val >= r_bounds[k].val_min)
                && (r_s1_item.pixel_val <= r_bounds[k].val_max);
        end
    end

    // stage 2: first hit wins
    always_comb begin
        s2_onehot = r_s2_match & (~r_s2_match + 1'b1);
        s2_found  = |r_s2_match;
        s2_hit    = '0;
        s2_fill   = '0;
        for (int k = 0; k < REGIONS; k++) begin
            if (s2_onehot[k]) begin
                s2_hit  = s2_hit | HIT_W'(k);
                s2_fill = s2_fill | r_fill[k];
            end
        end
    end

    // stage 2: output color
    always_comb begin
        n_s3_red   = r_s2_color[31:24];
        n_s3_green = r_s2_color[23:16];
        n_s3_blue  = r_s2_color[15:8];
        n_s3_alpha = r_s2_color[7:0];
        if (r_fill_mode == FILL_IDENTITY) begin
            n_s3_alpha = r_s2_color[7:0];
        end else if (s2_found) begin
            n_s3_red   = s2_fill[23:16];
            n_s3_green = s2_fill[15:8];
            n_s3_blue  = s2_fill[7:0];
            n_s3_alpha = (r_fill_mode == FILL_WHITE) ? CHAN_ZERO : CHAN_FULL;
        end else begin
            case (r_fill_mode)
                FILL_BLACK: begin
                    n_s3_red   = CHAN_ZERO;
                    n_s3_green = CHAN_ZERO;
                    n_s3_blue  = CHAN_ZERO;
                    n_s3_alpha = CHAN_FULL;
                end
                FILL_WHITE: begin
                    n_s3_red   = CHAN_FULL;
                    n_s3_green = CHAN_FULL;
                    n_s3_blue  = CHAN_FULL;
                    n_s3_alpha = CHAN_FULL;
                end
                FILL_MID_GRAY: begin
                    n_s3_red   = MID_GRAY;
                    n_s3_green = MID_GRAY;
                    n_s3_blue  = MID_GRAY;
                    n_s3_alpha = CHAN_FULL;
                end
                FILL_VALUE_GRAY: begin
                    n_s3_red   = r_s2_val;
                    n_s3_green = r_s2_val;
                    n_s3_blue  = r_s2_val;
                    n_s3_alpha = CHAN_FULL;
                end
                default: begin
                    n_s3_alpha = r_s2_color[7:0];
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= n_s1_item;
        end
        if (s1_adv && s1_keep) begin
            r_s2_cmd   <= r_s1_item.command;
            r_s2_index <= r_s1_item.region_index;
            r_s2_color <= r_s1_item.color_word;
            r_s2_val   <= r_s1_item.pixel_val;
            r_s2_match <= n_s2_match;
        end
        if (s2_adv && (r_s2_cmd == CMD_CLASSIFY)) begin
            r_s3_red     <= n_s3_red;
            r_s3_green   <= n_s3_green;
            r_s3_blue    <= n_s3_blue;
            r_s3_alpha   <= n_s3_alpha;
            r_s3_matched <= s2_found;
            r_s3_hit     <= REGION_HIT_W'(s2_hit);
        end
    end

    // table writes; an index past the table matches no entry
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < REGIONS; k++) begin
            if (s1_adv && (r_s1_item.command == CMD_LOAD)
                    && (int'(r_s1_item.region_index) == k)) begin
                r_bounds[k] <= r_s1_item.bounds;
            end
            if (s2_adv && (r_s2_cmd == CMD_LOAD) && (int'(r_s2_index) == k)) begin
                r_fill[k] <= r_s2_color[FILL_W-1:0];
            end
        end
    end

    // result channel
    assign o_res.valid      = r_s3_valid;
    assign o_res.red        = r_s3_red;
    assign o_res.green      = r_s3_green;
    assign o_res.blue       = r_s3_blue;
    assign o_res.alpha      = r_s3_alpha;
    assign o_res.matched    = r_s3_matched;
    assign o_res.region_hit = r_s3_hit;

    // checks
    `HSVCR_ASSERT_NOW(a_hit_zero_when_unmatched, o_res.valid && !o_res.matched,
        o_res.region_hit == '0, "region_hit set without a match")
    `HSVCR_ASSERT_NOW(a_white_match_clear_alpha,
        o_res.valid && o_res.matched && (r_fill_mode == FILL_WHITE),
        o_res.alpha == CHAN_ZERO, "white mode match must clear alpha")
    `HSVCR_ASSERT_NOW(a_no_match_without_regions,
        r_s2_valid && (r_s2_cmd == CMD_CLASSIFY) && (r_region_count == '0),
        r_s2_match == '0, "match reported with no regions in use")
    `HSVCR_ASSERT_NEXT(a_classify_reaches_output,
        r_s2_valid && (r_s2_cmd == CMD_CLASSIFY) && s3_free,
        r_s3_valid, "classified pixel lost between stage 2 and output")

endmodule
